[sv/asp_pkg.sv]
package asp_pkg;

  // Milliseconds that one tick moves the move clock on
  localparam int unsigned TICK_MS = 10;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SPD_W   = 10;
  localparam int unsigned OUT_W   = 13;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned PA_W    = SPD_W + 16;
  localparam int unsigned PB_W    = PA_W + LEN_W;
  localparam int unsigned RATIO_FRAC = 14;
  localparam int unsigned DIV_N_W = PB_W - RATIO_FRAC;
  localparam int unsigned DIV_D_W = LEN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

  typedef enum logic [IDX_W-1:0] {
    REG_ARC_GAIN      = 3'd0,
    REG_ACCEL_LIMIT   = 3'd1,
    REG_SPEED_CEILING = 3'd2,
    REG_RADIUS_RATIO  = 3'd3,
    REG_MOVE_LENGTH   = 3'd4,
    REG_PROFILE_KIND  = 3'd5,
    REG_SWAP_SIDES    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PROF_PROP = 2'd0,
    PROF_UP   = 2'd1,
    PROF_V    = 2'd2,
    PROF_DOWN = 2'd3
  } profile_e;

  typedef struct packed {
    logic [15:0]      arc_gain;
    logic [SPD_W-1:0] accel_limit;
    logic [SPD_W-1:0] speed_ceiling;
    logic [15:0]      radius_ratio;
    logic [LEN_W-1:0] move_length;
    profile_e         profile_kind;
    logic             swap_sides;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SLEW,
    ST_MUL1,
    ST_MUL2,
    ST_DIVGO,
    ST_DIVW,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic slew;
    logic mul1;
    logic mul2;
    logic div_start;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic long_path;
    logic div_done;
  } stat_t;

endpackage

[sv/asp_div.sv]
module asp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [asp_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [asp_pkg::DIV_D_W-1:0] divisor_i,
  output logic [asp_pkg::DIV_N_W-1:0] quotient_o,
  output logic                        done_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [asp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [asp_pkg::DIV_D_W-1:0]   rem_q, rem_d;
  logic [asp_pkg::DIV_D_W-1:0]   den_q;
  logic [asp_pkg::DIV_N_W-1:0]   quo_q;
  logic [asp_pkg::DIV_D_W:0]     shifted, diff;
  logic                          ge;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_q, quo_q[asp_pkg::DIV_N_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    rem_d   = ge ? diff[asp_pkg::DIV_D_W-1:0] : shifted[asp_pkg::DIV_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= asp_pkg::DIV_CNT_W'(asp_pkg::DIV_N_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - asp_pkg::DIV_CNT_W'(1);
      if (cnt_q == asp_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[asp_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[sv/asp_regs.sv]
module asp_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_i,
  input  logic [asp_pkg::IDX_W-1:0] idx_i,
  input  logic [asp_pkg::CFG_W-1:0] data_i,
  output asp_pkg::cfg_t             cfg_o
);

  asp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.arc_gain      <= 16'd256;
      cfg_q.accel_limit   <= '0;
      cfg_q.speed_ceiling <= asp_pkg::SPD_W'(100);
      cfg_q.radius_ratio  <= 16'd16384;
      cfg_q.move_length   <= '0;
      cfg_q.profile_kind  <= asp_pkg::PROF_PROP;
      cfg_q.swap_sides    <= 1'b0;
    end else if (wr_i) begin
      unique case (asp_pkg::cfg_reg_e'(idx_i))
        asp_pkg::REG_ARC_GAIN:      cfg_q.arc_gain      <= data_i;
        asp_pkg::REG_ACCEL_LIMIT:   cfg_q.accel_limit   <= data_i[asp_pkg::SPD_W-1:0];
        asp_pkg::REG_SPEED_CEILING: cfg_q.speed_ceiling <= data_i[asp_pkg::SPD_W-1:0];
        asp_pkg::REG_RADIUS_RATIO:  cfg_q.radius_ratio  <= data_i;
        asp_pkg::REG_MOVE_LENGTH:   cfg_q.move_length   <= data_i[asp_pkg::LEN_W-1:0];
        asp_pkg::REG_PROFILE_KIND:  cfg_q.profile_kind  <= asp_pkg::profile_e'(data_i[1:0]);
        asp_pkg::REG_SWAP_SIDES:    cfg_q.swap_sides    <= data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/asp_ctrl.sv]
module asp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  input  asp_pkg::stat_t stat_i,
  output asp_pkg::cmd_t  cmd_o
);

  asp_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      asp_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = asp_pkg::ST_PREP;
        end
      end
      asp_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.long_path ? asp_pkg::ST_SLEW : asp_pkg::ST_EMIT;
      end
      asp_pkg::ST_SLEW: begin
        cmd_o.slew = 1'b1;
        state_d    = asp_pkg::ST_MUL1;
      end
      asp_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = asp_pkg::ST_MUL2;
      end
      asp_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = asp_pkg::ST_DIVGO;
      end
      asp_pkg::ST_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = asp_pkg::ST_DIVW;
      end
      asp_pkg::ST_DIVW: begin
        if (stat_i.div_done) begin
          state_d = asp_pkg::ST_FIN;
        end
      end
      asp_pkg::ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = asp_pkg::ST_EMIT;
      end
      asp_pkg::ST_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = asp_pkg::ST_IDLE;
        end
      end
      default: state_d = asp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_tready_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over an untaken beat");

  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asp_pkg::ST_PREP && !stat_i.long_path) |=> state_q == asp_pkg::ST_EMIT)
    else $error("short tick did not go straight to emit");

  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == asp_pkg::ST_DIVW && stat_i.div_done) |=> state_q == asp_pkg::ST_FIN)
    else $error("divider completion missed");

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> state_q == asp_pkg::ST_PREP)
    else $error("accepted beat not taken into prep");

endmodule

[sv/asp_datapath.sv]
module asp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  asp_pkg::cfg_t             cfg_i,
  input  asp_pkg::cmd_t             cmd_i,
  output asp_pkg::stat_t            stat_o,
  input  logic                      begin_move_i,
  input  logic                      clear_slew_i,
  output logic [asp_pkg::OUT_W-1:0] left_o,
  output logic [asp_pkg::OUT_W-1:0] right_o,
  output logic                      moving_o,
  output logic                      finished_o
);

  localparam int unsigned LW = asp_pkg::LEN_W;
  localparam int unsigned SW = asp_pkg::SPD_W;
  localparam int unsigned OW = asp_pkg::OUT_W;
  localparam int unsigned NW = asp_pkg::DIV_N_W;

  // Move state
  logic [LW-1:0] elapsed_q;
  logic [SW-1:0] slew_q;
  logic          in_motion_q;
  logic [OW-1:0] held_l_q, held_r_q;

  // Per-tick working registers
  logic                  begin_q, clr_q;
  logic [LW-1:0]         t_q;
  logic [31:0]           prod_q;
  logic [SW-1:0]         sp_q;
  logic [LW-1:0]         num_q;
  logic [asp_pkg::PA_W-1:0] pa_q;
  logic [asp_pkg::PB_W-1:0] pb_q;
  logic [OW-1:0]         res_l_q, res_r_q;
  logic                  res_mov_q, res_fin_q;
  logic [OW-1:0]         out_l_q, out_r_q;
  logic                  out_mov_q, out_fin_q;

  logic          neg;
  logic [LW-1:0] len;
  logic          prof_low, zero_hold, ceil_prof;
  logic [SW-1:0] slew_eff;
  logic [LW-1:0] t_eff;
  logic          motion_eff, long_path, hold_start, ends_now;
  logic [OW-1:0] ended_l, ended_r;

  logic [23:0]   raw_target;
  logic [SW-1:0] target, sp;
  logic [SW:0]   hi;
  logic [SW-1:0] lo;
  logic [LW:0]   t2, lenx;
  logic [LW-1:0] num;

  logic [NW-1:0] quo;
  logic          div_done;
  logic [OW-1:0] inner, outer, new_l, new_r;
  logic [LW:0]   t10;
  logic          fin_end;

  asp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (pb_q[asp_pkg::PB_W-1:asp_pkg::RATIO_FRAC]),
    .divisor_i  (len),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign neg = cfg_i.move_length[LW-1];
  assign len = neg ? (~cfg_i.move_length + LW'(1)) : cfg_i.move_length;

  assign prof_low  = (cfg_i.profile_kind == asp_pkg::PROF_PROP) ||
                     (cfg_i.profile_kind == asp_pkg::PROF_UP);
  assign zero_hold = (cfg_i.profile_kind == asp_pkg::PROF_PROP) ||
                     (cfg_i.profile_kind == asp_pkg::PROF_DOWN);
  assign ceil_prof = (cfg_i.profile_kind == asp_pkg::PROF_UP) ||
                     (cfg_i.profile_kind == asp_pkg::PROF_V);

  // Front of the tick: start handling and end-of-move detection
  always_comb begin
    slew_eff   = clr_q ? '0 : slew_q;
    t_eff      = begin_q ? '0 : elapsed_q;
    motion_eff = begin_q || in_motion_q;
    hold_start = begin_q && prof_low;
    ends_now   = t_eff >= len;
    long_path  = !hold_start && motion_eff && !ends_now;
    ended_l    = zero_hold ? '0 : held_l_q;
    ended_r    = zero_hold ? '0 : held_r_q;
  end

  // Target, slew limit and ramp numerator
  always_comb begin
    raw_target = prod_q[31:8];
    if (ceil_prof || raw_target > 24'(cfg_i.speed_ceiling)) begin
      target = cfg_i.speed_ceiling;
    end else begin
      target = raw_target[SW-1:0];
    end
    hi = {1'b0, slew_q} + {1'b0, cfg_i.accel_limit};
    lo = slew_q - cfg_i.accel_limit;
    sp = target;
    if (cfg_i.accel_limit != '0) begin
      if ({1'b0, target} > hi) begin
        sp = hi[SW-1:0];
      end else if (slew_q >= cfg_i.accel_limit && target < lo) begin
        sp = lo;
      end
    end
    t2   = {t_q, 1'b0};
    lenx = {1'b0, len};
    case (cfg_i.profile_kind)
      asp_pkg::PROF_UP:   num = t_q;
      asp_pkg::PROF_V:    num = (lenx > t2) ? LW'(lenx - t2) : LW'(t2 - lenx);
      asp_pkg::PROF_DOWN: num = len - t_q;
      default:            num = len;
    endcase
  end

  // Back of the tick: sign, saturation, side selection and time advance
  always_comb begin
    if (!neg) begin
      inner = (quo > NW'(4095)) ? OW'(4095) : quo[OW-1:0];
    end else begin
      inner = (quo > NW'(4096)) ? OW'(4096) : (~quo[OW-1:0] + OW'(1));
    end
    outer   = neg ? (~{3'b0, sp_q} + OW'(1)) : {3'b0, sp_q};
    new_l   = cfg_i.swap_sides ? outer : inner;
    new_r   = cfg_i.swap_sides ? inner : outer;
    t10     = {1'b0, t_q} + (LW+1)'(asp_pkg::TICK_MS);
    fin_end = t10 >= {1'b0, len};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      slew_q      <= '0;
      in_motion_q <= 1'b0;
      held_l_q    <= '0;
      held_r_q    <= '0;
    end else if (cmd_i.prep) begin
      slew_q    <= slew_eff;
      elapsed_q <= t_eff;
      if (hold_start) begin
        held_l_q    <= '0;
        held_r_q    <= '0;
        in_motion_q <= len != '0;
      end else if (motion_eff && ends_now) begin
        held_l_q    <= ended_l;
        held_r_q    <= ended_r;
        in_motion_q <= 1'b0;
      end else begin
        in_motion_q <= motion_eff;
      end
    end else if (cmd_i.slew) begin
      slew_q <= sp;
    end else if (cmd_i.fin) begin
      elapsed_q   <= t10[LW-1:0];
      in_motion_q <= !fin_end;
      held_l_q    <= (fin_end && zero_hold) ? '0 : new_l;
      held_r_q    <= (fin_end && zero_hold) ? '0 : new_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      begin_q <= begin_move_i;
      clr_q   <= clear_slew_i;
    end
    if (cmd_i.prep) begin
      t_q    <= t_eff;
      prod_q <= 32'(len - t_eff) * 32'(cfg_i.arc_gain);
      if (hold_start) begin
        res_l_q   <= '0;
        res_r_q   <= '0;
        res_mov_q <= len != '0;
        res_fin_q <= len == '0;
      end else if (!motion_eff) begin
        res_l_q   <= held_l_q;
        res_r_q   <= held_r_q;
        res_mov_q <= 1'b0;
        res_fin_q <= 1'b0;
      end else begin
        res_l_q   <= ended_l;
        res_r_q   <= ended_r;
        res_mov_q <= 1'b0;
        res_fin_q <= 1'b1;
      end
    end
    if (cmd_i.slew) begin
      sp_q  <= sp;
      num_q <= num;
    end
    if (cmd_i.mul1) begin
      pa_q <= asp_pkg::PA_W'(sp_q) * asp_pkg::PA_W'(cfg_i.radius_ratio);
    end
    if (cmd_i.mul2) begin
      pb_q <= asp_pkg::PB_W'(pa_q) * asp_pkg::PB_W'(num_q);
    end
    if (cmd_i.fin) begin
      res_l_q   <= new_l;
      res_r_q   <= new_r;
      res_mov_q <= !fin_end;
      res_fin_q <= fin_end;
    end
    if (cmd_i.load_out) begin
      out_l_q   <= res_l_q;
      out_r_q   <= res_r_q;
      out_mov_q <= res_mov_q;
      out_fin_q <= res_fin_q;
    end
  end

  assign stat_o.long_path = long_path;
  assign stat_o.div_done  = div_done;

  assign left_o     = out_l_q;
  assign right_o    = out_r_q;
  assign moving_o   = out_mov_q;
  assign finished_o = out_fin_q;

endmodule

[sv/arc_drive_speed_profiler.sv]
// Channel      Dir  Handshake                     Payload
// s_axis       in   s_axis_tvalid/s_axis_tready   one tick command
// m_axis       out  m_axis_tvalid/m_axis_tready   wheel speed result, tlast = move ended
// cfg          in   cfg_valid_i/cfg_ready_o       register index and write data
//
// A start, end or idle tick: prep decides the path, then emit loads the result.
// A speed tick: target multiply, slew, two multiplies, then a 28-step restoring divider for the
// inner wheel ramp set the result before emit loads it.
// One tick is worked on at a time; the next beat is taken once the result sits in the
// output register, which holds it until the sink takes it.
// Reset clears the move state and loads the register defaults; no clearing pass.
module arc_drive_speed_profiler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [0] begin_move, [1] clear_slew
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // [12:0] left_speed, [25:13] right_speed,
                                                   // [26] moving
  output logic                      m_axis_tlast,  // finished
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [asp_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [asp_pkg::CFG_W-1:0] cfg_data_i
);

  asp_pkg::cfg_t  cfg;
  asp_pkg::cmd_t  cmd;
  asp_pkg::stat_t stat;

  logic [asp_pkg::OUT_W-1:0] left_speed, right_speed;
  logic                      moving, finished;

  // Registers accept a write on every cycle
  assign cfg_ready_o = 1'b1;

  asp_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_valid_i && cfg_ready_o),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Sequence the tick: capture beat, decide path, run the arithmetic, emit
  asp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  asp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .begin_move_i (s_axis_tdata[0]),
    .clear_slew_i (s_axis_tdata[1]),
    .left_o       (left_speed),
    .right_o      (right_speed),
    .moving_o     (moving),
    .finished_o   (finished)
  );

  // Pack result beat, lowest field first, pad to whole bytes
  assign m_axis_tdata = {5'b0, moving, right_speed, left_speed};
  assign m_axis_tlast = finished;

endmodule
